// File: hdl/lehmann_primality_test_defines.svh
// Assertion macros for the primality test checker.
// Depends on a clock named clock and a reset named reset in the using scope.
`ifndef LEHMANN_PRIMALITY_TEST_DEFINES_SVH
`define LEHMANN_PRIMALITY_TEST_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define LPT_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define LPT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// antecedent implies a delayed consequent
`define LPT_ASSERT_TWO(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##2 (cons)) \
      else $error(msg);

`endif

// File: hdl/lpt_pkg.sv
// Shared constants for the primality test block.
// No dependencies.
`timescale 1ns / 1ps

package lpt_pkg;
   localparam int IN_WIDTH          = 32;  // width of candidate and witness ports
   localparam int NUM_WIDTH_DEFAULT = 32;  // arithmetic width used by default
endpackage

// File: hdl/lpt_modmul.sv
// Iterative modular multiplier: x * y mod m, one bit of y per cycle, MSB first.
// Depends on lpt_pkg.
`timescale 1ns / 1ps

module lpt_modmul #(
   parameter int NUM_WIDTH = lpt_pkg::NUM_WIDTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 go,
   input  logic [NUM_WIDTH-1:0] x,      // must be below m
   input  logic [NUM_WIDTH-1:0] y,      // any value
   input  logic [NUM_WIDTH-1:0] m,
   output logic                 done,
   output logic [NUM_WIDTH-1:0] result
);
   import lpt_pkg::*;

   localparam int CNT_W = (NUM_WIDTH > 1) ? $clog2(NUM_WIDTH) : 1;

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [NUM_WIDTH-1:0] acc_ff, acc_in;
   logic [NUM_WIDTH-1:0] x_ff, x_in;
   logic [NUM_WIDTH-1:0] y_ff, y_in;
   logic [NUM_WIDTH-1:0] m_ff, m_in;

   logic [NUM_WIDTH:0]   dbl, dbl_red, sum, sum_red;
   logic [NUM_WIDTH-1:0] acc_step;

   // acc = 2*acc mod m, then + x mod m when the current y bit is set
   always_comb begin
      dbl      = {acc_ff, 1'b0};
      dbl_red  = (dbl >= {1'b0, m_ff}) ? (dbl - {1'b0, m_ff}) : dbl;
      sum      = {1'b0, dbl_red[NUM_WIDTH-1:0]} + {1'b0, x_ff};
      sum_red  = (sum >= {1'b0, m_ff}) ? (sum - {1'b0, m_ff}) : sum;
      acc_step = y_ff[NUM_WIDTH-1] ? sum_red[NUM_WIDTH-1:0] : dbl_red[NUM_WIDTH-1:0];
   end

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      m_in    = m_ff;
      if (go) begin
         run_in = 1'b1;
         cnt_in = CNT_W'(NUM_WIDTH - 1);
         acc_in = '0;
         x_in   = x;
         y_in   = y;
         m_in   = m;
      end else if (run_ff) begin
         acc_in = acc_step;
         y_in   = {y_ff[NUM_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      m_ff   <= m_in;
   end

   assign done   = done_ff;
   assign result = acc_ff;

endmodule

// File: hdl/lehmann_primality_test.sv
// Lehmann primality test, one round per transaction; top level.
// Depends on lpt_pkg and lpt_modmul.
`timescale 1ns / 1ps

// Each transaction is one round: candidate p, witness a, last-round mark.
// A transaction is taken when start is high and busy is low; busy then stays
// high until the round is finished. Candidates 2 and 3 are prime; 0, 1 and
// other even numbers are composite. Otherwise the round computes a^((p-1)/2)
// mod p by LSB-first square-and-multiply on one shared iterative modular
// multiplier that retires one operand bit per cycle. Any result other than
// 1 or p-1 marks the candidate composite until the last round. A verdict
// appears only on a last round: rsp_valid is high for exactly one cycle with
// rsp_verdict (1 probably prime, 0 composite), and the receiver cannot hold
// it off. After the last round the composite mark is cleared. Only the low
// NUM_WIDTH bits of candidate and witness are used.
module lehmann_primality_test #(
   parameter int NUM_WIDTH = lpt_pkg::NUM_WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [lpt_pkg::IN_WIDTH-1:0] req_candidate,
   input  logic [lpt_pkg::IN_WIDTH-1:0] req_witness,
   input  logic                         req_last_round,
   output logic                         rsp_valid,
   output logic                         rsp_verdict
);
   import lpt_pkg::*;

   typedef enum logic [2:0] {
      IDLE,     // waiting for a transaction
      REDUCE,   // witness mod p
      STEP,     // inspect next exponent bit
      MUL_ACC,  // acc = acc * b mod p
      SQUARE,   // b = b * b mod p
      FINISH    // report on last round
   } state_type;

   state_type            state_ff, state_in;
   logic [NUM_WIDTH-1:0] p_ff, p_in;
   logic                 last_ff, last_in;
   logic [NUM_WIDTH-2:0] e_ff, e_in;       // remaining exponent
   logic [NUM_WIDTH-1:0] acc_ff, acc_in;
   logic [NUM_WIDTH-1:0] b_ff, b_in;
   logic                 still_ff, still_in;
   logic                 verdict_ff, verdict_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 mul_go_ff, mul_go_in;
   logic [NUM_WIDTH-1:0] op_x_ff, op_x_in;
   logic [NUM_WIDTH-1:0] op_y_ff, op_y_in;

   logic                 mul_done;
   logic [NUM_WIDTH-1:0] mul_res;
   logic [NUM_WIDTH-1:0] cand, wit;
   logic                 is_two_three, is_trivial, round_fail;

   lpt_modmul #(.NUM_WIDTH(NUM_WIDTH)) u_modmul (
      .clock  (clock),
      .reset  (reset),
      .go     (mul_go_ff),
      .x      (op_x_ff),
      .y      (op_y_ff),
      .m      (p_ff),
      .done   (mul_done),
      .result (mul_res)
   );

   assign cand = req_candidate[NUM_WIDTH-1:0];
   assign wit  = req_witness[NUM_WIDTH-1:0];

   // 2 and 3 are prime; below 2 or even is composite
   assign is_two_three = (cand == NUM_WIDTH'(2)) || (cand == NUM_WIDTH'(3));
   assign is_trivial   = is_two_three || (cand < NUM_WIDTH'(2)) || !cand[0];

   // round fails unless the power is 1 or p-1
   assign round_fail = (acc_ff != NUM_WIDTH'(1)) && (acc_ff != (p_ff - NUM_WIDTH'(1)));

   always_comb begin
      state_in     = state_ff;
      p_in         = p_ff;
      last_in      = last_ff;
      e_in         = e_ff;
      acc_in       = acc_ff;
      b_in         = b_ff;
      still_in     = still_ff;
      verdict_in   = verdict_ff;
      rsp_valid_in = 1'b0;
      mul_go_in    = 1'b0;
      op_x_in      = op_x_ff;
      op_y_in      = op_y_ff;
      unique case (state_ff)
         IDLE: begin
            if (start) begin
               p_in    = cand;
               last_in = req_last_round;
               if (is_trivial) begin
                  verdict_in = is_two_three;
                  state_in   = FINISH;
               end else begin
                  // p odd, so (p-1)/2 is p >> 1
                  e_in      = cand[NUM_WIDTH-1:1];
                  acc_in    = NUM_WIDTH'(1);
                  op_x_in   = NUM_WIDTH'(1);
                  op_y_in   = wit;
                  mul_go_in = 1'b1;
                  state_in  = REDUCE;
               end
            end
         end
         REDUCE: begin
            if (mul_done) begin
               b_in     = mul_res;
               state_in = STEP;
            end
         end
         STEP: begin
            if (e_ff == '0) begin
               still_in   = still_ff && !round_fail;
               verdict_in = still_ff && !round_fail;
               state_in   = FINISH;
            end else if (e_ff[0]) begin
               op_x_in   = acc_ff;
               op_y_in   = b_ff;
               mul_go_in = 1'b1;
               state_in  = MUL_ACC;
            end else begin
               op_x_in   = b_ff;
               op_y_in   = b_ff;
               mul_go_in = 1'b1;
               state_in  = SQUARE;
            end
         end
         MUL_ACC: begin
            if (mul_done) begin
               acc_in = mul_res;
               if (e_ff == (NUM_WIDTH-1)'(1)) begin
                  // top bit done: final square not needed
                  e_in     = '0;
                  state_in = STEP;
               end else begin
                  op_x_in   = b_ff;
                  op_y_in   = b_ff;
                  mul_go_in = 1'b1;
                  state_in  = SQUARE;
               end
            end
         end
         SQUARE: begin
            if (mul_done) begin
               b_in     = mul_res;
               e_in     = e_ff >> 1;
               state_in = STEP;
            end
         end
         FINISH: begin
            if (last_ff) begin
               rsp_valid_in = 1'b1;
               still_in     = 1'b1;
            end
            state_in = IDLE;
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         still_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
         mul_go_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         still_ff     <= still_in;
         rsp_valid_ff <= rsp_valid_in;
         mul_go_ff    <= mul_go_in;
      end
      p_ff       <= p_in;
      last_ff    <= last_in;
      e_ff       <= e_in;
      acc_ff     <= acc_in;
      b_ff       <= b_in;
      verdict_ff <= verdict_in;
      op_x_ff    <= op_x_in;
      op_y_ff    <= op_y_in;
   end

   assign busy        = (state_ff != IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = verdict_ff;

endmodule

// File: hdl/lpt_checker.sv
// Port-level checker for the primality test, bound to the top level.
// Depends on lpt_pkg and lehmann_primality_test_defines.svh.
`timescale 1ns / 1ps
`include "lehmann_primality_test_defines.svh"

module lpt_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic [lpt_pkg::IN_WIDTH-1:0] req_candidate,
   input logic                         req_last_round,
   input logic                         rsp_valid,
   input logic                         rsp_verdict
);
   import lpt_pkg::*;

   logic two_last_accept;

   // last round of candidate two taken
   assign two_last_accept = start && !busy && req_last_round &&
                            (req_candidate == IN_WIDTH'(2));

   // accepted transaction makes the block busy
   `LPT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
   // a verdict is a one-cycle strobe
   `LPT_ASSERT_NEXT(a_rsp_pulse, rsp_valid, !rsp_valid, "rsp_valid held longer than one cycle")
   // a verdict is only shown once the round is finished
   `LPT_ASSERT_SAME(a_rsp_idle, rsp_valid, !busy, "verdict shown while busy")
   // last round of candidate two reports prime
   `LPT_ASSERT_TWO(a_two_prime, two_last_accept, rsp_valid && rsp_verdict, "two not reported prime")

endmodule

bind lehmann_primality_test lpt_checker u_lpt_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_candidate  (req_candidate),
   .req_last_round (req_last_round),
   .rsp_valid      (rsp_valid),
   .rsp_verdict    (rsp_verdict)
);
